// ----- hw/rtl/bpd_pkg.sv -----
// ----------------------------------------------------------------------------
// bpd_pkg
// Types, constants and the keyword ROM of the BASIC program detokenizer.
// ----------------------------------------------------------------------------
package bpd_pkg;

  localparam int unsigned BPD_QUEUE_DEPTH = 4;
  localparam int unsigned KW_MAX_LEN      = 9;

  localparam logic [7:0] PREFIX_CE  = 8'hCE;
  localparam logic [7:0] PREFIX_FE  = 8'hFE;
  localparam logic [7:0] TOKEN_BASE = 8'h80;
  localparam logic [15:0] TOKEN_REM = 16'h008F;
  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [16:0] DIV10_RECIP = 17'd52429;

  localparam logic [1:0] CFG_LOAD_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_PROGRAM_SPAN = 2'd1;
  localparam logic [1:0] CFG_OUTPUT_LIMIT = 2'd2;
  localparam logic [1:0] CFG_CRLF_NEWLINE = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_SPAN     = 3'd1;
  localparam logic [2:0] ERR_CHAIN    = 3'd2;
  localparam logic [2:0] ERR_TOKEN    = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  typedef enum logic [7:0] {
    CTX_BEGIN   = 8'b0000_0001,
    CTX_LINK_LO = 8'b0000_0010,
    CTX_LINK_HI = 8'b0000_0100,
    CTX_NUM_LO  = 8'b0000_1000,
    CTX_NUM_HI  = 8'b0001_0000,
    CTX_TEXT    = 8'b0010_0000,
    CTX_QUOTE   = 8'b0100_0000,
    CTX_REMARK  = 8'b1000_0000
  } ctx_e;

  typedef enum logic [2:0] {
    KIND_CHAR   = 3'd0,
    KIND_NL     = 3'd1,
    KIND_KW     = 3'd2,
    KIND_NUM    = 3'd3,
    KIND_STATUS = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_CONV = 3'b010,
    BK_EMIT = 3'b100
  } back_state_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] data;
    logic [2:0]  err;
    logic        done;
    logic [15:0] line;
  } job_t;

  typedef struct packed {
    logic [15:0] load_address;
    logic [15:0] program_span;
    logic [20:0] output_limit;
    logic        crlf_newline;
  } cfg_t;

  // keyword text, right aligned: first character in the highest used byte
  function automatic logic [71:0] kw_rom(input logic [15:0] code);
    logic [71:0] t;
    t = '0;
    case (code)
      16'h0080: t = 72'("end");      16'h0081: t = 72'("for");
      16'h0082: t = 72'("next");     16'h0083: t = 72'("data");
      16'h0084: t = 72'("input#");   16'h0085: t = 72'("input");
      16'h0086: t = 72'("dim");      16'h0087: t = 72'("read");
      16'h0088: t = 72'("let");      16'h0089: t = 72'("goto");
      16'h008A: t = 72'("run");      16'h008B: t = 72'("if");
      16'h008C: t = 72'("restore");  16'h008D: t = 72'("gosub");
      16'h008E: t = 72'("return");   16'h008F: t = 72'("rem");
      16'h0090: t = 72'("stop");     16'h0091: t = 72'("on");
      16'h0092: t = 72'("wait");     16'h0093: t = 72'("load");
      16'h0094: t = 72'("save");     16'h0095: t = 72'("verify");
      16'h0096: t = 72'("def");      16'h0097: t = 72'("poke");
      16'h0098: t = 72'("print#");   16'h0099: t = 72'("print");
      16'h009A: t = 72'("cont");     16'h009B: t = 72'("list");
      16'h009C: t = 72'("clr");      16'h009D: t = 72'("cmd");
      16'h009E: t = 72'("sys");      16'h009F: t = 72'("open");
      16'h00A0: t = 72'("close");    16'h00A1: t = 72'("get");
      16'h00A2: t = 72'("new");      16'h00A3: t = 72'("tab(");
      16'h00A4: t = 72'("to");       16'h00A5: t = 72'("fn");
      16'h00A6: t = 72'("spc(");     16'h00A7: t = 72'("then");
      16'h00A8: t = 72'("not");      16'h00A9: t = 72'("step");
      16'h00AA: t = 72'("+");        16'h00AB: t = 72'("-");
      16'h00AC: t = 72'("*");        16'h00AD: t = 72'("/");
      16'h00AE: t = 72'("^");        16'h00AF: t = 72'("and");
      16'h00B0: t = 72'("or");       16'h00B1: t = 72'(">");
      16'h00B2: t = 72'("=");        16'h00B3: t = 72'("<");
      16'h00B4: t = 72'("sgn");      16'h00B5: t = 72'("int");
      16'h00B6: t = 72'("abs");      16'h00B7: t = 72'("usr");
      16'h00B8: t = 72'("fre");      16'h00B9: t = 72'("pos");
      16'h00BA: t = 72'("sqr");      16'h00BB: t = 72'("rnd");
      16'h00BC: t = 72'("log");      16'h00BD: t = 72'("exp");
      16'h00BE: t = 72'("cos");      16'h00BF: t = 72'("sin");
      16'h00C0: t = 72'("tan");      16'h00C1: t = 72'("atn");
      16'h00C2: t = 72'("peek");     16'h00C3: t = 72'("len");
      16'h00C4: t = 72'("str$");     16'h00C5: t = 72'("val");
      16'h00C6: t = 72'("asc");      16'h00C7: t = 72'("chr$");
      16'h00C8: t = 72'("left$");    16'h00C9: t = 72'("right$");
      16'h00CA: t = 72'("mid$");     16'h00CB: t = 72'("go");
      16'h00CC: t = 72'("rgr");      16'h00CD: t = 72'("rclr");
      16'h00CF: t = 72'("joy");
      16'h00D0: t = 72'("rdot");     16'h00D1: t = 72'("dec");
      16'h00D2: t = 72'("hex$");     16'h00D3: t = 72'("err$");
      16'h00D4: t = 72'("instr");    16'h00D5: t = 72'("else");
      16'h00D6: t = 72'("resume");   16'h00D7: t = 72'("trap");
      16'h00D8: t = 72'("tron");     16'h00D9: t = 72'("troff");
      16'h00DA: t = 72'("sound");    16'h00DB: t = 72'("vol");
      16'h00DC: t = 72'("auto");     16'h00DD: t = 72'("pudef");
      16'h00DE: t = 72'("graphic");  16'h00DF: t = 72'("paint");
      16'h00E0: t = 72'("char");     16'h00E1: t = 72'("box");
      16'h00E2: t = 72'("circle");   16'h00E3: t = 72'("gshape");
      16'h00E4: t = 72'("sshape");   16'h00E5: t = 72'("draw");
      16'h00E6: t = 72'("locate");   16'h00E7: t = 72'("color");
      16'h00E8: t = 72'("scnclr");   16'h00E9: t = 72'("scale");
      16'h00EA: t = 72'("help");     16'h00EB: t = 72'("do");
      16'h00EC: t = 72'("loop");     16'h00ED: t = 72'("exit");
      16'h00EE: t = 72'("directory"); 16'h00EF: t = 72'("dsave");
      16'h00F0: t = 72'("dload");    16'h00F1: t = 72'("header");
      16'h00F2: t = 72'("scratch");  16'h00F3: t = 72'("collect");
      16'h00F4: t = 72'("copy");     16'h00F5: t = 72'("rename");
      16'h00F6: t = 72'("backup");   16'h00F7: t = 72'("delete");
      16'h00F8: t = 72'("renumber"); 16'h00F9: t = 72'("key");
      16'h00FA: t = 72'("monitor");  16'h00FB: t = 72'("using");
      16'h00FC: t = 72'("until");    16'h00FD: t = 72'("while");
      16'hCE02: t = 72'("pot");      16'hCE03: t = 72'("bump");
      16'hCE04: t = 72'("pen");      16'hCE05: t = 72'("rsppos");
      16'hCE06: t = 72'("rsprite");  16'hCE07: t = 72'("rspcolor");
      16'hCE08: t = 72'("xor");      16'hCE09: t = 72'("rwindow");
      16'hCE0A: t = 72'("pointer");
      16'hFE02: t = 72'("bank");     16'hFE03: t = 72'("filter");
      16'hFE04: t = 72'("play");     16'hFE05: t = 72'("tempo");
      16'hFE06: t = 72'("movspr");   16'hFE07: t = 72'("sprite");
      16'hFE08: t = 72'("sprcolor"); 16'hFE09: t = 72'("rreg");
      16'hFE0A: t = 72'("envelope"); 16'hFE0B: t = 72'("sleep");
      16'hFE0C: t = 72'("catalog");  16'hFE0D: t = 72'("dopen");
      16'hFE0E: t = 72'("append");   16'hFE0F: t = 72'("dclose");
      16'hFE10: t = 72'("bsave");    16'hFE11: t = 72'("bload");
      16'hFE12: t = 72'("record");   16'hFE13: t = 72'("concat");
      16'hFE14: t = 72'("dverify");  16'hFE15: t = 72'("dclear");
      16'hFE16: t = 72'("sprsav");   16'hFE17: t = 72'("collision");
      16'hFE18: t = 72'("begin");    16'hFE19: t = 72'("bend");
      16'hFE1A: t = 72'("window");   16'hFE1B: t = 72'("boot");
      16'hFE1C: t = 72'("width");    16'hFE1D: t = 72'("sprdef");
      16'hFE1E: t = 72'("quit");     16'hFE1F: t = 72'("stash");
      16'hFE21: t = 72'("fetch");    16'hFE23: t = 72'("swap");
      16'hFE24: t = 72'("off");      16'hFE25: t = 72'("fast");
      16'hFE26: t = 72'("slow");
      default:  t = '0;
    endcase
    return t;
  endfunction

  // number of characters in a right-aligned keyword, 0 when unassigned
  function automatic logic [3:0] kw_len(input logic [71:0] t);
    logic [3:0] l;
    l = '0;
    for (int k = 0; k < KW_MAX_LEN; k++) begin
      if (t[k*8 +: 8] != 8'd0) l = 4'(k + 1);
    end
    return l;
  endfunction

endpackage

// ----- hw/rtl/bpd_front.sv -----
// ----------------------------------------------------------------------------
// bpd_front
// Parses program bytes: link chaining, line numbers, tokens, quote and REM
// tracking; turns each byte into at most one job for the back end.
// ----------------------------------------------------------------------------
module bpd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    byte_i,
  input  bpd_pkg::cfg_t cfg_i,
  output logic          push_o,
  output bpd_pkg::job_t job_o
);
  import bpd_pkg::*;

  ctx_e        ctx_q, ctx_d;
  logic [15:0] link_q, link_d;
  logic [15:0] cur_line_q, cur_line_d;
  logic [15:0] prev_line_q, prev_line_d;
  logic [7:0]  prefix_q, prefix_d;
  logic [16:0] index_q, index_d;
  logic        halt_q, halt_d;
  logic [15:0] here;
  logic [7:0]  c;

  assign here = cfg_i.load_address + index_q[15:0];

  always_comb begin
    ctx_d       = ctx_q;
    link_d      = link_q;
    cur_line_d  = cur_line_q;
    prev_line_d = prev_line_q;
    prefix_d    = prefix_q;
    index_d     = index_q;
    halt_d      = halt_q;
    push_o      = 1'b0;
    job_o       = '{kind: KIND_CHAR, data: '0, err: ERR_NONE, done: 1'b0, line: cur_line_q};
    c           = byte_i;
    if (accept_i && !halt_q) begin
      if (index_q > {1'b0, cfg_i.program_span}) begin
        halt_d     = 1'b1;
        push_o     = 1'b1;
        job_o.kind = KIND_STATUS;
        job_o.err  = ERR_SPAN;
        job_o.line = prev_line_q;
      end else begin
        index_d = index_q + 17'd1;
        case (ctx_q)
          CTX_BEGIN: begin
            link_d = {8'd0, byte_i};
            ctx_d  = CTX_LINK_HI;
          end
          CTX_LINK_LO: begin
            if (link_q != here) begin
              halt_d     = 1'b1;
              push_o     = 1'b1;
              job_o.kind = KIND_STATUS;
              job_o.err  = ERR_CHAIN;
            end else begin
              link_d = {8'd0, byte_i};
              ctx_d  = CTX_LINK_HI;
            end
          end
          CTX_LINK_HI: begin
            link_d = {byte_i, link_q[7:0]};
            if (link_d == 16'd0) begin
              halt_d     = 1'b1;
              push_o     = 1'b1;
              job_o.kind = KIND_STATUS;
              job_o.done = 1'b1;
            end else begin
              ctx_d = CTX_NUM_LO;
            end
          end
          CTX_NUM_LO: begin
            prev_line_d = cur_line_q;
            cur_line_d  = {8'd0, byte_i};
            ctx_d       = CTX_NUM_HI;
          end
          CTX_NUM_HI: begin
            cur_line_d = {byte_i, cur_line_q[7:0]};
            ctx_d      = CTX_TEXT;
            push_o     = 1'b1;
            job_o.kind = KIND_NUM;
            job_o.data = cur_line_d;
            job_o.line = cur_line_d;
          end
          default: begin
            if (ctx_q == CTX_TEXT && (byte_i >= TOKEN_BASE || prefix_q != 8'd0)) begin
              if ((byte_i == PREFIX_CE || byte_i == PREFIX_FE) && prefix_q == 8'd0) begin
                prefix_d = byte_i;
              end else begin
                prefix_d   = 8'd0;
                push_o     = 1'b1;
                job_o.kind = KIND_KW;
                job_o.data = {prefix_q, byte_i};
                if ({prefix_q, byte_i} == TOKEN_REM) ctx_d = CTX_REMARK;
              end
            end else if (byte_i == 8'd0) begin
              ctx_d      = CTX_LINK_LO;
              push_o     = 1'b1;
              job_o.kind = KIND_NL;
            end else begin
              if (byte_i == CHR_QUOTE) begin
                if (ctx_q == CTX_TEXT) ctx_d = CTX_QUOTE;
                else if (ctx_q == CTX_QUOTE) ctx_d = CTX_TEXT;
              end
              // fold letters 0x41-0x5A to lower case and shifted letters to upper case
              if (byte_i >= 8'h41 && byte_i <= 8'h5A) c = byte_i + 8'h20;
              else if (byte_i >= 8'hC1 && byte_i <= 8'hDA) c = byte_i & 8'h7F;
              push_o     = 1'b1;
              job_o.kind = KIND_CHAR;
              job_o.data = {8'd0, c};
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q       <= CTX_BEGIN;
      link_q      <= '0;
      cur_line_q  <= '1;
      prev_line_q <= '1;
      prefix_q    <= '0;
      index_q     <= '0;
      halt_q      <= 1'b0;
    end else begin
      ctx_q       <= ctx_d;
      link_q      <= link_d;
      cur_line_q  <= cur_line_d;
      prev_line_q <= prev_line_d;
      prefix_q    <= prefix_d;
      index_q     <= index_d;
      halt_q      <= halt_d;
    end
  end

endmodule

// ----- hw/rtl/bpd_queue.sv -----
// ----------------------------------------------------------------------------
// bpd_queue
// Small job queue between the parser and the text expander.
// ----------------------------------------------------------------------------
module bpd_queue #(
  parameter int unsigned Depth = bpd_pkg::BPD_QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bpd_pkg::job_t job_i,
  input  logic          pop_i,
  output bpd_pkg::job_t job_o,
  output logic          empty_o,
  output logic          full_o
);
  import bpd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

// ----- hw/rtl/bpd_back.sv -----
// ----------------------------------------------------------------------------
// bpd_back
// Expands jobs into listing characters: line number digits, keywords,
// newlines and status results; enforces the output limit.
// ----------------------------------------------------------------------------
module bpd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bpd_pkg::cfg_t cfg_i,
  input  bpd_pkg::job_t job_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output logic          m_char_valid_o,
  output logic [7:0]    m_char_o,
  output logic          m_last_o,
  output logic          m_done_o,
  output logic [2:0]    m_err_o,
  output logic [15:0]   m_line_o
);
  import bpd_pkg::*;

  back_state_e state_q, state_d;
  logic [7:0]  buf_q [KW_MAX_LEN];
  logic [7:0]  buf_d [KW_MAX_LEN];
  logic [3:0]  idx_q, idx_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [15:0] val_q, val_d;
  logic        stat_q, stat_d;
  logic [2:0]  err_q, err_d;
  logic        done_q, done_d;
  logic [15:0] line_q, line_d;
  logic [20:0] chars_q, chars_d;
  logic        halt_q, halt_d;

  logic        ov_q, ov_d;
  logic        oc_valid_q, oc_valid_d;
  logic [7:0]  oc_q, oc_d;
  logic        ol_q, ol_d;
  logic        od_q, od_d;
  logic [2:0]  oe_q, oe_d;
  logic [15:0] oln_q, oln_d;

  logic        adv;
  logic [71:0] kw_text;
  logic [3:0]  kw_n;
  logic [32:0] prod;
  logic [15:0] quo;
  logic [15:0] rem;

  assign adv     = !ov_q || m_ready_i;
  assign kw_text = kw_rom(job_i.data);
  assign kw_n    = kw_len(kw_text);
  // divide by ten through the reciprocal, exact for 16-bit values
  assign prod    = {17'd0, val_q} * {16'd0, DIV10_RECIP};
  assign quo     = {3'd0, prod[31:19]};
  assign rem     = val_q - ((quo << 3) + (quo << 1));

  always_comb begin
    state_d    = state_q;
    buf_d      = buf_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    val_d      = val_q;
    stat_d     = stat_q;
    err_d      = err_q;
    done_d     = done_q;
    line_d     = line_q;
    chars_d    = chars_q;
    halt_d     = halt_q;
    pop_o      = 1'b0;
    ov_d       = adv ? 1'b0 : ov_q;
    oc_valid_d = oc_valid_q;
    oc_d       = oc_q;
    ol_d       = ol_q;
    od_d       = od_q;
    oe_d       = oe_q;
    oln_d      = oln_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (!halt_q) begin
            line_d  = job_i.line;
            stat_d  = 1'b0;
            err_d   = ERR_NONE;
            done_d  = 1'b0;
            state_d = BK_EMIT;
            case (job_i.kind)
              KIND_CHAR: begin
                buf_d[0] = job_i.data[7:0];
                idx_d    = 4'd0;
              end
              KIND_NL: begin
                buf_d[0] = CHR_LF;
                buf_d[1] = CHR_CR;
                idx_d    = cfg_i.crlf_newline ? 4'd1 : 4'd0;
              end
              KIND_KW: begin
                if (kw_n == 4'd0) begin
                  stat_d = 1'b1;
                  err_d  = ERR_TOKEN;
                end else begin
                  for (int k = 0; k < KW_MAX_LEN; k++) buf_d[k] = kw_text[k*8 +: 8];
                  idx_d = kw_n - 4'd1;
                end
              end
              KIND_NUM: begin
                buf_d[0] = CHR_SPACE;
                val_d    = job_i.data;
                cnt_d    = 3'd0;
                idx_d    = 4'd5;
                state_d  = BK_CONV;
              end
              KIND_STATUS: begin
                stat_d = 1'b1;
                err_d  = job_i.err;
                done_d = job_i.done;
              end
              default: begin
                stat_d = 1'b1;
              end
            endcase
          end
        end
      end
      BK_CONV: begin
        // digits from the units column up; leading zeros become blanks
        buf_d[4'(cnt_q) + 4'd1] = (val_q == 16'd0 && cnt_q != 3'd0) ?
                                  CHR_SPACE : CHR_ZERO + rem[7:0];
        val_d = quo;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd4) state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (adv) begin
          ov_d  = 1'b1;
          oln_d = line_q;
          od_d  = 1'b0;
          if (stat_q || chars_q >= cfg_i.output_limit) begin
            oc_valid_d = 1'b0;
            oc_d       = 8'd0;
            ol_d       = 1'b1;
            od_d       = stat_q & done_q;
            oe_d       = stat_q ? err_q : ERR_OVERFLOW;
            halt_d     = 1'b1;
            state_d    = BK_IDLE;
          end else begin
            oc_valid_d = 1'b1;
            oc_d       = buf_q[idx_q];
            ol_d       = (idx_q == 4'd0);
            oe_d       = ERR_NONE;
            chars_d    = chars_q + 21'd1;
            idx_d      = idx_q - 4'd1;
            if (idx_q == 4'd0) state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    val_q  <= val_d;
    stat_q <= stat_d;
    err_q  <= err_d;
    done_q <= done_d;
    line_q <= line_d;
    oc_valid_q <= oc_valid_d;
    oc_q   <= oc_d;
    ol_q   <= ol_d;
    od_q   <= od_d;
    oe_q   <= oe_d;
    oln_q  <= oln_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      chars_q <= '0;
      halt_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      chars_q <= chars_d;
      halt_q  <= halt_d;
      ov_q    <= ov_d;
    end
  end

  assign m_valid_o      = ov_q;
  assign m_char_valid_o = oc_valid_q;
  assign m_char_o       = oc_q;
  assign m_last_o       = ol_q;
  assign m_done_o       = od_q;
  assign m_err_o        = oe_q;
  assign m_line_o       = oln_q;

endmodule

// ----- hw/rtl/basic_program_detokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// basic_program_detokenizer_unit
// Turns a tokenized BASIC 10 program image into listing text.
// ----------------------------------------------------------------------------
// Program bytes enter on the slave stream, one byte per transfer. Listing
// characters leave on the master stream; tuser high marks a character,
// tuser low a status result (error code or program end), and tlast marks the
// final result caused by one input byte. Bytes that print nothing (link
// bytes, low line-number byte, token prefix) give no result unless they end
// the program or raise an error. The parser takes one byte per cycle into a
// job queue while the queue has room; the expander finishes each job before
// it takes the next, converting a line number to digits before it emits the
// characters. The expander is the limit: when it falls behind or the
// receiver stalls, the queue fills and then tready drops. After an error or
// the end of the program the block swallows every further byte without
// output until reset. Reset restores the register defaults and the start of
// program state; the user must make configuration writes only while the
// block is idle, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module basic_program_detokenizer_unit #(
  parameter int unsigned QueueDepth = bpd_pkg::BPD_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] prg_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] text_char, [8] program_done,
                                        // [11:9] error_code, [27:12] line_number
  output logic        m_axis_tuser_o,   // [0] char_valid
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [20:0] cfg_data_i
);
  import bpd_pkg::*;

  cfg_t        cfg_q;
  job_t        push_job, head_job;
  logic        push, pop, empty, full;
  logic        ch_valid, last, done;
  logic [7:0]  ch;
  logic [2:0]  err;
  logic [15:0] line;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.load_address <= 16'd8193;
      cfg_q.program_span <= 16'hFFFF;
      cfg_q.output_limit <= 21'd1048576;
      cfg_q.crlf_newline <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOAD_ADDRESS: cfg_q.load_address <= cfg_data_i[15:0];
        CFG_PROGRAM_SPAN: cfg_q.program_span <= cfg_data_i[15:0];
        CFG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_data_i;
        CFG_CRLF_NEWLINE: cfg_q.crlf_newline <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = !full;

  bpd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (s_axis_tvalid_i && s_axis_tready_o),
    .byte_i   (s_axis_tdata_i),
    .cfg_i    (cfg_q),
    .push_o   (push),
    .job_o    (push_job)
  );

  bpd_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (empty),
    .full_o  (full)
  );

  bpd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .job_i          (head_job),
    .empty_i        (empty),
    .pop_o          (pop),
    .m_valid_o      (m_axis_tvalid_o),
    .m_ready_i      (m_axis_tready_i),
    .m_char_valid_o (ch_valid),
    .m_char_o       (ch),
    .m_last_o       (last),
    .m_done_o       (done),
    .m_err_o        (err),
    .m_line_o       (line)
  );

  assign m_axis_tdata_o = {4'd0, line, err, done, ch};
  assign m_axis_tuser_o = ch_valid;
  assign m_axis_tlast_o = last;

endmodule

// ----- hw/rtl/bpd_checker.sv -----
// ----------------------------------------------------------------------------
// bpd_checker
// Port-level checks of the detokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module bpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed under stall");

  // characters carry no status
  a_char_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[11:8] == 4'd0)
    else $error("character with status bits");

  // a status result ends the output of its byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("status result without tlast");

  // nothing follows an error or the program end
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tuser_o |=> !m_axis_tvalid_o)
    else $error("output after halt");

endmodule

bind basic_program_detokenizer_unit bpd_checker u_bpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
